// ===== hw/rtl/bpa_pkg.sv =====
// Shared constants for the buddy page allocator.
// Holds field widths, register defaults and register addresses; no dependencies.
package bpa_pkg;

    localparam int LeavesDefault = 1024;
    localparam int SizeW = 12;
    localparam int PageW = 10;
    localparam int PagesW = 11;
    localparam int PoolW = 11;
    localparam int AddrW = 2;
    localparam int DataW = 32;

    localparam logic [PoolW-1:0] PoolReset = 11'd1024;
    localparam logic [AddrW-1:0] RegPool = 2'd0;

endpackage

// ===== hw/rtl/bpa_mark_mem.sv =====
// Mark bit memory of the buddy allocator: one bit per tree node, one read and one write port.
// Runs a clearing pass over all entries after reset; uses no package.
module bpa_mark_mem #(
    parameter int AW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    output logic          init_busy
);

    logic          mem [2**AW];
    logic          rd_data_reg;
    logic [AW-1:0] clr_reg;
    logic          init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            init_reg <= 1'b1;
        end
        else if (init_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == '1)
            begin
                init_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_reg)
        begin
            mem[clr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign init_busy = init_reg;

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Sequencer of the buddy allocator: scans candidate blocks, climbs on free, and walks
// subtrees node by node through the mark memory. Depends on bpa_pkg.
module bpa_ctrl #(
    parameter int LEAVES = bpa_pkg::LeavesDefault,
    parameter int NW = $clog2(LEAVES) + 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       mode,
    input  logic [bpa_pkg::SizeW-1:0]  size_pages,
    input  logic [bpa_pkg::PageW-1:0]  page_index,
    input  logic [bpa_pkg::PoolW-1:0]  pool_pages,
    output logic                       busy,
    output logic                       done,
    output logic                       success,
    output logic [bpa_pkg::PageW-1:0]  block_start,
    output logic [bpa_pkg::PagesW-1:0] block_pages,
    output logic [NW-1:0]              mem_rd_addr,
    input  logic                       mem_rd_data,
    output logic                       mem_wr_en,
    output logic [NW-1:0]              mem_wr_addr,
    output logic                       mem_wr_data,
    input  logic                       init_busy
);

    localparam int LW = $clog2(LEAVES);
    localparam int LVW = $clog2(LW + 1);
    localparam int CW = (NW + 1 > 12) ? NW + 1 : 12;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ANEXT = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CK    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_CLIMB = 3'd5;
    localparam logic [2:0] S_PREV  = 3'd6;

    localparam logic [1:0] PH_ACHK   = 2'd0;
    localparam logic [1:0] PH_FCLIMB = 2'd1;
    localparam logic [1:0] PH_FTOP   = 2'd2;
    localparam logic [1:0] PH_SET    = 2'd3;

    logic [2:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [NW-1:0]               node_reg, node_next;
    logic [LVW-1:0]              lv_reg, lv_next;
    logic [NW-1:0]               idx_reg, idx_next;
    logic [NW-1:0]               prev_reg, prev_next;
    logic [LVW-1:0]              plv_reg, plv_next;
    logic [NW-1:0]               cur_reg, cur_next;
    logic [NW-1:0]               first_reg, first_next;
    logic [NW-1:0]               last_reg, last_next;
    logic                        want_reg, want_next;
    logic                        done_reg, done_next;
    logic                        success_reg, success_next;
    logic [bpa_pkg::PageW-1:0]   start_reg, start_next;
    logic [bpa_pkg::PagesW-1:0]  pages_reg, pages_next;

    logic [LVW-1:0] k;
    logic [NW-1:0]  base;
    logic [NW-1:0]  cand;
    logic [CW-1:0]  span;
    logic [CW-1:0]  fp_a;
    logic [CW-1:0]  fp_n;
    logic           fits_a;
    logic           fits_n;
    logic           at_last;
    logic           walk_done;

    always_comb
    begin
        k = LVW'(LW);
        for (int i = LW; i >= 0; i--)
        begin
            if ((CW'(1) << i) >= CW'(size_pages))
            begin
                k = LVW'(i);
            end
        end
    end

    assign base      = NW'(LEAVES) >> lv_reg;
    assign cand      = base + idx_reg;
    assign span      = CW'(1) << lv_reg;
    assign fp_a      = (CW'(cand) << lv_reg) - CW'(LEAVES);
    assign fp_n      = (CW'(node_reg) << lv_reg) - CW'(LEAVES);
    assign fits_a    = (fp_a + span) <= CW'(pool_pages);
    assign fits_n    = (fp_n + span) <= CW'(pool_pages);
    assign at_last   = cur_reg == last_reg;
    assign walk_done = at_last && (first_reg >= NW'(LEAVES));

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        node_next    = node_reg;
        lv_next      = lv_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        plv_next     = plv_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        want_next    = want_reg;
        done_next    = 1'b0;
        success_next = success_reg;
        start_next   = start_reg;
        pages_next   = pages_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !init_busy)
                begin
                    if (!mode)
                    begin
                        if (CW'(size_pages) > CW'(LEAVES))
                        begin
                            done_next    = 1'b1;
                            success_next = 1'b0;
                            start_next   = '0;
                            pages_next   = '0;
                        end
                        else
                        begin
                            lv_next    = k;
                            idx_next   = '0;
                            state_next = S_ANEXT;
                        end
                    end
                    else
                    begin
                        if (CW'(page_index) >= CW'(LEAVES))
                        begin
                            done_next    = 1'b1;
                            success_next = 1'b0;
                            start_next   = '0;
                            pages_next   = '0;
                        end
                        else
                        begin
                            node_next  = NW'(LEAVES) + NW'(page_index);
                            lv_next    = '0;
                            prev_next  = '0;
                            plv_next   = '0;
                            state_next = S_CLIMB;
                        end
                    end
                end
            end
            S_ANEXT:
            begin
                if (idx_reg == base || !fits_a)
                begin
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    start_next   = '0;
                    pages_next   = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    node_next  = cand;
                    cur_next   = cand;
                    first_next = cand;
                    last_next  = cand;
                    want_next  = 1'b0;
                    phase_next = PH_ACHK;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CK;
            end
            S_CK:
            begin
                if (mem_rd_data != want_reg)
                begin
                    if (phase_reg == PH_ACHK)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ANEXT;
                    end
                    else
                    begin
                        state_next = S_PREV;
                    end
                end
                else if (walk_done)
                begin
                    case (phase_reg)
                        PH_FCLIMB:
                        begin
                            prev_next  = node_reg;
                            plv_next   = lv_reg;
                            node_next  = node_reg >> 1;
                            lv_next    = lv_reg + 1'b1;
                            state_next = S_CLIMB;
                        end
                        default:
                        begin
                            cur_next   = node_reg;
                            first_next = node_reg;
                            last_next  = node_reg;
                            want_next  = (phase_reg == PH_ACHK);
                            phase_next = PH_SET;
                            state_next = S_WR;
                        end
                    endcase
                end
                else
                begin
                    if (at_last)
                    begin
                        first_next = first_reg << 1;
                        last_next  = {last_reg[NW-2:0], 1'b1};
                        cur_next   = first_reg << 1;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                    state_next = S_RD;
                end
            end
            S_WR:
            begin
                if (walk_done)
                begin
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    start_next   = fp_n[bpa_pkg::PageW-1:0];
                    pages_next   = span[bpa_pkg::PagesW-1:0];
                    state_next   = S_IDLE;
                end
                else if (at_last)
                begin
                    first_next = first_reg << 1;
                    last_next  = {last_reg[NW-2:0], 1'b1};
                    cur_next   = first_reg << 1;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_CLIMB:
            begin
                if (!fits_n)
                begin
                    state_next = S_PREV;
                end
                else
                begin
                    cur_next   = node_reg;
                    first_next = node_reg;
                    last_next  = node_reg;
                    want_next  = 1'b1;
                    phase_next = node_reg[0] ? PH_FTOP : PH_FCLIMB;
                    state_next = S_RD;
                end
            end
            S_PREV:
            begin
                if (prev_reg != '0)
                begin
                    node_next  = prev_reg;
                    lv_next    = plv_reg;
                    cur_next   = prev_reg;
                    first_next = prev_reg;
                    last_next  = prev_reg;
                    want_next  = 1'b0;
                    phase_next = PH_SET;
                    state_next = S_WR;
                end
                else
                begin
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    start_next   = '0;
                    pages_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= phase_next;
        node_reg    <= node_next;
        lv_reg      <= lv_next;
        idx_reg     <= idx_next;
        prev_reg    <= prev_next;
        plv_reg     <= plv_next;
        cur_reg     <= cur_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        want_reg    <= want_next;
        success_reg <= success_next;
        start_reg   <= start_next;
        pages_reg   <= pages_next;
    end

    assign busy        = (state_reg != S_IDLE) || init_busy;
    assign done        = done_reg;
    assign success     = success_reg;
    assign block_start = start_reg;
    assign block_pages = pages_reg;
    assign mem_rd_addr = cur_reg;
    assign mem_wr_en   = state_reg == S_WR;
    assign mem_wr_addr = cur_reg;
    assign mem_wr_data = want_reg;

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Buddy page allocator top level: APB register, sequencer and mark memory.
// Depends on bpa_pkg, bpa_mark_mem and bpa_ctrl.
// Each tree node read passes a read state and a check state, each node written a write state;
// an allocate visits the subtrees of the scanned blocks, a free those it climbs through.
// One word is in flight at a time, bounded by the single mark memory port pair.
// After reset a clearing pass over all 2*LEAVES mark entries runs with busy high; the result strobe
// done lasts one cycle and cannot be stalled.
module buddy_page_allocator #(
    parameter int LEAVES = bpa_pkg::LeavesDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        mode,
    input  logic [bpa_pkg::SizeW-1:0]   size_pages,
    input  logic [bpa_pkg::PageW-1:0]   page_index,
    output logic                        done,
    output logic                        success,
    output logic [bpa_pkg::PageW-1:0]   block_start,
    output logic [bpa_pkg::PagesW-1:0]  block_pages,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpa_pkg::AddrW-1:0]   paddr,
    input  logic [bpa_pkg::DataW-1:0]   pwdata,
    output logic [bpa_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    localparam int NW = $clog2(LEAVES) + 1;

    logic [bpa_pkg::PoolW-1:0] pool_reg;
    logic [NW-1:0]             mem_rd_addr;
    logic                      mem_rd_data;
    logic                      mem_wr_en;
    logic [NW-1:0]             mem_wr_addr;
    logic                      mem_wr_data;
    logic                      init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= bpa_pkg::PoolReset;
        end
        else if (psel && penable && pwrite && paddr == bpa_pkg::RegPool)
        begin
            pool_reg <= pwdata[bpa_pkg::PoolW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == bpa_pkg::RegPool)
                    ? {{(bpa_pkg::DataW - bpa_pkg::PoolW){1'b0}}, pool_reg} : '0;

    bpa_mark_mem #(
        .AW(NW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .init_busy(init_busy)
    );

    bpa_ctrl #(
        .LEAVES(LEAVES),
        .NW    (NW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .size_pages (size_pages),
        .page_index (page_index),
        .pool_pages (pool_reg),
        .busy       (busy),
        .done       (done),
        .success    (success),
        .block_start(block_start),
        .block_pages(block_pages),
        .mem_rd_addr(mem_rd_addr),
        .mem_rd_data(mem_rd_data),
        .mem_wr_en  (mem_wr_en),
        .mem_wr_addr(mem_wr_addr),
        .mem_wr_data(mem_wr_data),
        .init_busy  (init_busy)
    );

endmodule
